// ===== rtl/rmst_pkg.sv =====
// Shared types, command codes and default values for the render-mode state tracker.
// No dependencies; every other file refers to this package by scoped names.
package rmst_pkg;

	// Command opcodes, bits 31..24 of the first command word
	localparam logic [7:0] OP_ENV_COLOR  = 8'hFB;
	localparam logic [7:0] OP_PRIM_COLOR = 8'hFA;
	localparam logic [7:0] OP_MODE_LOW   = 8'hB9;
	localparam logic [7:0] OP_MODE_HIGH  = 8'hBA;
	localparam logic [7:0] OP_MODE_FULL  = 8'hEF;
	localparam logic [7:0] OP_GEOM_CLEAR = 8'hB6;
	localparam logic [7:0] OP_GEOM_SET   = 8'hB7;

	// Other-mode and geometry-mode bit masks
	localparam logic [31:0] RENDER_MASK    = 32'hFFFF_FFF8;
	localparam logic [31:0] HIGH_MASK      = 32'h00FF_FFFF;
	localparam logic [31:0] ZMODE_FIELD    = 32'h0000_0C00;
	localparam logic [31:0] ZCMP_BIT       = 32'h0000_0010;
	localparam logic [31:0] ZUPD_BIT       = 32'h0000_0020;
	localparam logic [31:0] FORCE_BLEND    = 32'h0000_4000;
	localparam logic [31:0] ALPHA_TEST_MSK = 32'h0000_1003;
	localparam logic [31:0] ENV_MAP_MSK    = 32'h0006_0000;
	localparam logic [31:0] ENV_LIN_BIT    = 32'h0008_0000;
	localparam int unsigned CULL_BACK_POS  = 13;
	localparam int unsigned CULL_FRONT_POS = 12;

	// Defaults loaded on reset and restart
	localparam logic [7:0]  ALPHA_DEFAULT    = 8'hFF;
	localparam logic [31:0] MODE_LOW_OPAQUE  = 32'h0000_0030;
	localparam logic [31:0] MODE_LOW_TRANSL  = 32'h0000_4810;
	localparam logic [31:0] GEOM_DEFAULT     = 32'h0000_0205;

	typedef enum logic [2:0] {
		CLS_UNKNOWN,
		CLS_OPAQUE,
		CLS_CUTOUT,
		CLS_CUTOUT_BLEND,
		CLS_BLEND,
		CLS_DECAL
	} tclass_t;

	typedef struct packed {
		logic        restart;
		logic [31:0] command_high;
		logic [31:0] command_low;
	} in_item_t;

	typedef struct packed {
		logic       depth_test;
		logic       depth_write;
		logic       decal_mode;
		logic       force_blend;
		logic       alpha_test;
		logic       env_mapping;
		logic       env_linear;
		logic [2:0] transparency_class;
		logic [7:0] env_alpha_out;
		logic [7:0] prim_alpha_out;
		logic       cull_back;
		logic       cull_front;
	} out_item_t;

	typedef struct packed {
		logic [7:0]  env_alpha;
		logic [7:0]  prim_alpha;
		logic [31:0] mode_low;
		logic [31:0] mode_low_known;
		logic [31:0] mode_high;
		logic [31:0] mode_high_known;
		logic [31:0] geometry_bits;
		logic [31:0] geometry_known;
		logic        depth_buffer_on;
	} state_t;

	// Tracker state after reset or restart
	function automatic state_t defaults(input logic secondary);
		state_t s;
		s.env_alpha       = ALPHA_DEFAULT;
		s.prim_alpha      = ALPHA_DEFAULT;
		s.mode_low        = secondary ? MODE_LOW_TRANSL : MODE_LOW_OPAQUE;
		s.mode_low_known  = '0;
		s.mode_high       = '0;
		s.mode_high_known = '0;
		s.geometry_bits   = GEOM_DEFAULT;
		s.geometry_known  = '0;
		s.depth_buffer_on = 1'b1;
		return s;
	endfunction

endpackage

// ===== rtl/render_mode_state_tracker_top.sv =====
// Render-mode state tracker: one display-list command in, one set of derived raster flags out
// per beat. Each accepted command is captured in an input register; from there it updates the
// tracked other-mode, geometry-mode and alpha state and the derived flags land in an output
// register, which takes them when it is empty or being drained. A new command can be taken
// every cycle while the output register is not stalled. The rate is one beat per cycle in that
// case, set by the single update of the state register from the staged command. The output
// register stalls only the input stage behind it.
// The secondary_pass register chooses the other-mode default used on restart; reset loads the opaque one.
// Uses rmst_pkg and rmst_update.
module render_mode_state_tracker_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  rmst_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output rmst_pkg::out_item_t out_item
);

	logic                secondary_q;
	logic                valid_s1;
	rmst_pkg::in_item_t  item_s1;
	logic                valid_s2;
	rmst_pkg::out_item_t result_s2;
	rmst_pkg::state_t    state_q;
	rmst_pkg::state_t    state_nxt;
	rmst_pkg::out_item_t result_nxt;
	logic                advance;
	logic                in_fire;

	// Move the staged beat forward when the output register is free or being drained
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign in_fire  = in_valid && in_ready;

	// Hold the configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			secondary_q <= 1'b0;
		end else if (cfg_we) begin
			secondary_q <= cfg_wdata;
		end
	end

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1 <= in_item;
		end
	end

	rmst_update u_update (
		.cur       (state_q),
		.item      (item_s1),
		.secondary (secondary_q),
		.nxt       (state_nxt),
		.res       (result_nxt)
	);

	// Advance tracked state once per staged beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rmst_pkg::defaults(1'b0);
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_nxt;
		end
	end

	assign out_valid = valid_s2;
	assign out_item  = result_s2;

	// A restart beat reports default alphas
	a_restart_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.restart |=> result_s2.env_alpha_out == rmst_pkg::ALPHA_DEFAULT
			&& result_s2.prim_alpha_out == rmst_pkg::ALPHA_DEFAULT)
		else $error("restart did not reload alphas");

	// An empty output register never blocks the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> in_ready)
		else $error("input stalled with empty output register");

	// Depth update is suppressed in decal mode
	a_no_zwrite_decal: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(result_s2.depth_write && result_s2.decal_mode))
		else $error("depth write with decal mode");

	// Decal class only with decal depth mode
	a_decal_class: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && result_s2.transparency_class == rmst_pkg::CLS_DECAL
			|-> result_s2.decal_mode)
		else $error("decal class without decal depth mode");

	// Linear generation implies environment mapping
	a_env_linear: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && result_s2.env_linear |-> result_s2.env_mapping)
		else $error("linear environment flag without environment mapping");

endmodule

// ===== rtl/rmst_update.sv =====
// Next-state decode and flag derivation for one command beat.
// Depends on rmst_pkg for the item, result and state types and the opcodes.
module rmst_update (
	input  rmst_pkg::state_t    cur,
	input  rmst_pkg::in_item_t  item,
	input  logic                secondary,
	output rmst_pkg::state_t    nxt,
	output rmst_pkg::out_item_t res
);

	logic [7:0]  opcode;
	logic [7:0]  shift;
	logic [7:0]  count;
	logic [8:0]  span;
	logic        mw_ok;
	logic [31:0] ones;
	logic [31:0] mw_mask;
	logic        decal;
	logic        atest;
	logic        blend;
	logic        env;
	rmst_pkg::tclass_t cls;

	assign opcode = item.command_high[31:24];
	assign shift  = item.command_high[15:8];
	assign count  = item.command_high[7:0];

	// Masked write field: accept only a nonzero count that fits in 32 bits from the shift
	assign span    = {1'b0, shift} + {1'b0, count};
	assign mw_ok   = (count != 8'd0) && (span <= 9'd32);
	assign ones    = (count == 8'd32) ? 32'hFFFF_FFFF : ~(32'hFFFF_FFFF << count[4:0]);
	assign mw_mask = mw_ok ? (ones << shift[4:0]) : 32'h0;

	// Apply the command, or reload defaults on restart
	always_comb begin
		nxt = cur;
		if (item.restart) begin
			nxt = rmst_pkg::defaults(secondary);
		end else begin
			unique case (opcode)
				rmst_pkg::OP_ENV_COLOR: begin
					nxt.env_alpha = item.command_low[7:0];
				end
				rmst_pkg::OP_PRIM_COLOR: begin
					nxt.prim_alpha = item.command_low[7:0];
				end
				rmst_pkg::OP_MODE_LOW: begin
					nxt.mode_low = (cur.mode_low & ~mw_mask) | (item.command_low & mw_mask);
					nxt.mode_low_known = cur.mode_low_known | mw_mask;
				end
				rmst_pkg::OP_MODE_HIGH: begin
					nxt.mode_high = (cur.mode_high & ~mw_mask) | (item.command_low & mw_mask);
					nxt.mode_high_known = cur.mode_high_known | mw_mask;
				end
				rmst_pkg::OP_MODE_FULL: begin
					nxt.mode_low        = item.command_low;
					nxt.mode_low_known  = 32'hFFFF_FFFF;
					nxt.mode_high       = item.command_high & rmst_pkg::HIGH_MASK;
					nxt.mode_high_known = rmst_pkg::HIGH_MASK;
				end
				rmst_pkg::OP_GEOM_CLEAR: begin
					nxt.geometry_known = cur.geometry_known | item.command_low;
					nxt.geometry_bits  = cur.geometry_bits & ~item.command_low;
					if (item.command_low[0]) begin
						nxt.depth_buffer_on = 1'b0;
					end
				end
				rmst_pkg::OP_GEOM_SET: begin
					nxt.geometry_known = cur.geometry_known | item.command_low;
					nxt.geometry_bits  = cur.geometry_bits | item.command_low;
					if (item.command_low[0]) begin
						nxt.depth_buffer_on = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Derive flags from the updated state
	assign decal = (nxt.mode_low & rmst_pkg::ZMODE_FIELD) == rmst_pkg::ZMODE_FIELD;
	assign atest = (nxt.mode_low & rmst_pkg::ALPHA_TEST_MSK) != 32'h0;
	assign blend = (nxt.mode_low & rmst_pkg::FORCE_BLEND) != 32'h0;
	assign env   = (nxt.geometry_bits & rmst_pkg::ENV_MAP_MSK) == rmst_pkg::ENV_MAP_MSK;

	// Classify transparency once the whole render mode has been authored
	always_comb begin
		if ((nxt.mode_low_known & rmst_pkg::RENDER_MASK) != rmst_pkg::RENDER_MASK) begin
			cls = rmst_pkg::CLS_UNKNOWN;
		end else if (decal) begin
			cls = rmst_pkg::CLS_DECAL;
		end else if (atest && blend) begin
			cls = rmst_pkg::CLS_CUTOUT_BLEND;
		end else if (atest) begin
			cls = rmst_pkg::CLS_CUTOUT;
		end else if (blend) begin
			cls = rmst_pkg::CLS_BLEND;
		end else begin
			cls = rmst_pkg::CLS_OPAQUE;
		end
	end

	always_comb begin
		res.depth_test  = nxt.depth_buffer_on && ((nxt.mode_low & rmst_pkg::ZCMP_BIT) != 32'h0);
		res.depth_write = nxt.depth_buffer_on && ((nxt.mode_low & rmst_pkg::ZUPD_BIT) != 32'h0)
			&& !decal;
		res.decal_mode  = decal;
		res.force_blend = blend;
		res.alpha_test  = atest;
		res.env_mapping = env;
		res.env_linear  = env && ((nxt.geometry_bits & rmst_pkg::ENV_LIN_BIT) != 32'h0);
		res.transparency_class = cls;
		res.env_alpha_out  = nxt.env_alpha;
		res.prim_alpha_out = nxt.prim_alpha;
		// Unauthored cull sides fall back to back-face culling only
		res.cull_back  = nxt.geometry_known[rmst_pkg::CULL_BACK_POS]
			? nxt.geometry_bits[rmst_pkg::CULL_BACK_POS] : 1'b1;
		res.cull_front = nxt.geometry_known[rmst_pkg::CULL_FRONT_POS]
			? nxt.geometry_bits[rmst_pkg::CULL_FRONT_POS] : 1'b0;
	end

endmodule

// ===== tb/rmst_flags_checker.sv =====
// Result checker for the render-mode state tracker: predicts the raster flags of each command
// beat and compares them field by field with the result beats. Depends on rmst_pkg only.
`timescale 1ns / 100ps
module rmst_flags_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_wdata,
	input  logic                in_valid,
	input  logic                in_ready,
	input  rmst_pkg::in_item_t  in_item,
	input  logic                out_valid,
	input  logic                out_ready,
	input  rmst_pkg::out_item_t out_item,
	output int                  outstanding,
	output int                  mismatches
);

	localparam logic [31:0] ZBUF_BIT = 32'h0000_0001;

	typedef struct packed {
		logic [7:0]  env_a;
		logic [7:0]  prim_a;
		logic [31:0] other_lo;
		logic [31:0] other_lo_known;
		logic [31:0] other_hi;
		logic [31:0] other_hi_known;
		logic [31:0] geom;
		logic [31:0] geom_known;
		logic        zbuf_on;
	} tracker_t;

	tracker_t            trk;
	tracker_t            next_trk;
	logic                sec_pass;
	rmst_pkg::out_item_t flags_due[$];
	int                  mismatch_count = 0;

	assign mismatches = mismatch_count;

	// Tracker contents after reset or a restart beat
	function automatic tracker_t restart_state(input logic secondary);
		tracker_t s;
		s = '0;
		s.env_a    = rmst_pkg::ALPHA_DEFAULT;
		s.prim_a   = rmst_pkg::ALPHA_DEFAULT;
		s.other_lo = secondary ? rmst_pkg::MODE_LOW_TRANSL : rmst_pkg::MODE_LOW_OPAQUE;
		s.geom     = rmst_pkg::GEOM_DEFAULT;
		s.zbuf_on  = 1'b1;
		return s;
	endfunction

	// Bits covered by a masked other-mode write; zero when shift or count is out of range
	function automatic logic [31:0] span_mask(input logic [31:0] hdr);
		int unsigned sh;
		int unsigned cnt;
		logic [63:0] ones;
		sh  = 32'(hdr[15:8]);
		cnt = 32'(hdr[7:0]);
		if (cnt == 0 || sh >= 32 || cnt > 32 - sh)
			return '0;
		ones = (64'd1 << cnt) - 64'd1;
		return ones[31:0] << sh;
	endfunction

	// Apply one command beat to the tracked state
	function automatic tracker_t advance(input tracker_t cur, input rmst_pkg::in_item_t it,
			input logic secondary);
		tracker_t    s;
		logic [31:0] hi;
		logic [31:0] lo;
		logic [31:0] m;
		s  = cur;
		hi = it.command_high;
		lo = it.command_low;
		if (it.restart)
			return restart_state(secondary);
		case (hi[31:24])
			rmst_pkg::OP_ENV_COLOR:  s.env_a = lo[7:0];
			rmst_pkg::OP_PRIM_COLOR: s.prim_a = lo[7:0];
			rmst_pkg::OP_MODE_LOW: begin
				m = span_mask(hi);
				s.other_lo       = (s.other_lo & ~m) | (lo & m);
				s.other_lo_known = s.other_lo_known | m;
			end
			rmst_pkg::OP_MODE_HIGH: begin
				m = span_mask(hi);
				s.other_hi       = (s.other_hi & ~m) | (lo & m);
				s.other_hi_known = s.other_hi_known | m;
			end
			rmst_pkg::OP_MODE_FULL: begin
				s.other_lo       = lo;
				s.other_lo_known = '1;
				s.other_hi       = hi & rmst_pkg::HIGH_MASK;
				s.other_hi_known = rmst_pkg::HIGH_MASK;
			end
			rmst_pkg::OP_GEOM_CLEAR: begin
				s.geom_known = s.geom_known | lo;
				s.geom       = s.geom & ~lo;
				if ((lo & ZBUF_BIT) != 0)
					s.zbuf_on = 1'b0;
			end
			rmst_pkg::OP_GEOM_SET: begin
				s.geom_known = s.geom_known | lo;
				s.geom       = s.geom | lo;
				if ((lo & ZBUF_BIT) != 0)
					s.zbuf_on = 1'b1;
			end
			default: ;
		endcase
		return s;
	endfunction

	// Derive the result beat from the updated state
	function automatic rmst_pkg::out_item_t derive_flags(input tracker_t s);
		rmst_pkg::out_item_t r;
		logic                decal;
		logic                atest;
		logic                blend;
		decal = (s.other_lo & rmst_pkg::ZMODE_FIELD) == rmst_pkg::ZMODE_FIELD;
		atest = (s.other_lo & rmst_pkg::ALPHA_TEST_MSK) != 0;
		blend = (s.other_lo & rmst_pkg::FORCE_BLEND) != 0;
		r.depth_test  = s.zbuf_on && (s.other_lo & rmst_pkg::ZCMP_BIT) != 0;
		r.depth_write = s.zbuf_on && (s.other_lo & rmst_pkg::ZUPD_BIT) != 0 && !decal;
		r.decal_mode  = decal;
		r.force_blend = blend;
		r.alpha_test  = atest;
		r.env_mapping = (s.geom & rmst_pkg::ENV_MAP_MSK) == rmst_pkg::ENV_MAP_MSK;
		r.env_linear  = r.env_mapping && (s.geom & rmst_pkg::ENV_LIN_BIT) != 0;
		if ((s.other_lo_known & rmst_pkg::RENDER_MASK) != rmst_pkg::RENDER_MASK)
			r.transparency_class = rmst_pkg::CLS_UNKNOWN;
		else if (decal)
			r.transparency_class = rmst_pkg::CLS_DECAL;
		else if (atest && blend)
			r.transparency_class = rmst_pkg::CLS_CUTOUT_BLEND;
		else if (atest)
			r.transparency_class = rmst_pkg::CLS_CUTOUT;
		else if (blend)
			r.transparency_class = rmst_pkg::CLS_BLEND;
		else
			r.transparency_class = rmst_pkg::CLS_OPAQUE;
		r.env_alpha_out  = s.env_a;
		r.prim_alpha_out = s.prim_a;
		r.cull_back  = s.geom_known[rmst_pkg::CULL_BACK_POS]
			? s.geom[rmst_pkg::CULL_BACK_POS] : 1'b1;
		r.cull_front = s.geom_known[rmst_pkg::CULL_FRONT_POS]
			? s.geom[rmst_pkg::CULL_FRONT_POS] : 1'b0;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("[%0t] flags mismatch on %s: got %0h, want %0h", $time, what, got, want);
		mismatch_count++;
	endtask

	task automatic compare_flags(input rmst_pkg::out_item_t got,
			input rmst_pkg::out_item_t want);
		if (got.depth_test !== want.depth_test)
			report_mismatch("depth_test", 32'(got.depth_test), 32'(want.depth_test));
		if (got.depth_write !== want.depth_write)
			report_mismatch("depth_write", 32'(got.depth_write), 32'(want.depth_write));
		if (got.decal_mode !== want.decal_mode)
			report_mismatch("decal_mode", 32'(got.decal_mode), 32'(want.decal_mode));
		if (got.force_blend !== want.force_blend)
			report_mismatch("force_blend", 32'(got.force_blend), 32'(want.force_blend));
		if (got.alpha_test !== want.alpha_test)
			report_mismatch("alpha_test", 32'(got.alpha_test), 32'(want.alpha_test));
		if (got.env_mapping !== want.env_mapping)
			report_mismatch("env_mapping", 32'(got.env_mapping), 32'(want.env_mapping));
		if (got.env_linear !== want.env_linear)
			report_mismatch("env_linear", 32'(got.env_linear), 32'(want.env_linear));
		if (got.transparency_class !== want.transparency_class)
			report_mismatch("transparency_class", 32'(got.transparency_class),
				32'(want.transparency_class));
		if (got.env_alpha_out !== want.env_alpha_out)
			report_mismatch("env_alpha_out", 32'(got.env_alpha_out),
				32'(want.env_alpha_out));
		if (got.prim_alpha_out !== want.prim_alpha_out)
			report_mismatch("prim_alpha_out", 32'(got.prim_alpha_out),
				32'(want.prim_alpha_out));
		if (got.cull_back !== want.cull_back)
			report_mismatch("cull_back", 32'(got.cull_back), 32'(want.cull_back));
		if (got.cull_front !== want.cull_front)
			report_mismatch("cull_front", 32'(got.cull_front), 32'(want.cull_front));
	endtask

	// Retire result beats, predict command beats, track the secondary-pass register
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_pass <= 1'b0;
			trk <= restart_state(1'b0);
			flags_due.delete();
			outstanding <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (flags_due.size() == 0)
					report_mismatch("result beat with none pending", 32'(out_item), '0);
				else
					compare_flags(out_item, flags_due.pop_front());
			end
			if (in_valid && in_ready) begin
				next_trk = advance(trk, in_item, sec_pass);
				trk <= next_trk;
				flags_due.push_back(derive_flags(next_trk));
			end
			if (cfg_we)
				sec_pass <= cfg_wdata;
			outstanding <= flags_due.size();
		end
	end

endmodule

// ===== tb/render_mode_state_tracker_top_test.sv =====
// Testbench top for the render-mode state tracker: clock, reset, command stimulus, result
// back-pressure and verdict. Depends on rmst_pkg, the tracker RTL and rmst_flags_checker.
`timescale 1ns / 100ps
module render_mode_state_tracker_top_test;

	localparam int          CYCLE_LIMIT     = 200000;
	localparam int          HOLD_CYCLES     = 64;
	localparam int          PHASES          = 6;
	localparam int          ITEMS_PER_PHASE = 75;
	localparam logic [7:0]  OP_UNKNOWN_LO   = 8'h00;
	localparam logic [7:0]  OP_UNKNOWN_HI   = 8'hFF;
	localparam logic [31:0] ZBUF_BIT        = 32'h0000_0001;
	localparam logic [31:0] GEOM_WATCHED    = rmst_pkg::ENV_MAP_MSK | rmst_pkg::ENV_LIN_BIT
		| ZBUF_BIT | (32'd1 << rmst_pkg::CULL_BACK_POS) | (32'd1 << rmst_pkg::CULL_FRONT_POS);

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic                cfg_wdata;
	logic                in_valid;
	logic                in_ready;
	rmst_pkg::in_item_t  in_item;
	logic                out_valid;
	logic                out_ready;
	rmst_pkg::out_item_t out_item;
	int                  outstanding;
	int                  mismatches;
	int                  cycle_count;
	int                  hold_asked;
	int                  hold_taken;

	render_mode_state_tracker_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	rmst_flags_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_item     (in_item),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_item    (out_item),
		.outstanding (outstanding),
		.mismatches  (mismatches)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Bound the run
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	// Result side: stall in random segments, hold off entirely when asked
	initial begin : receiver
		int seg_left;
		int stall_pct;
		int hold_left;
		out_ready = 1'b0;
		hold_taken = 0;
		seg_left = 0;
		stall_pct = 0;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_left == 0 && hold_taken != hold_asked) begin
				hold_taken++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				if (seg_left == 0) begin
					seg_left = $urandom_range(10, 80);
					case ($urandom_range(0, 4))
						0, 1:    stall_pct = 0;
						2:       stall_pct = 20;
						3:       stall_pct = 50;
						default: stall_pct = 85;
					endcase
				end
				seg_left--;
				out_ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	function automatic rmst_pkg::in_item_t make_cmd(input logic [7:0] op,
			input logic [23:0] arg, input logic [31:0] lo);
		return rmst_pkg::in_item_t'{1'b0, {op, arg}, lo};
	endfunction

	function automatic rmst_pkg::in_item_t span_cmd(input logic [7:0] op,
			input logic [7:0] shift, input logic [7:0] count, input logic [31:0] lo);
		return make_cmd(op, {8'h00, shift, count}, lo);
	endfunction

	// Mostly well-formed commands with random content, some noise
	function automatic rmst_pkg::in_item_t random_cmd();
		rmst_pkg::in_item_t it;
		int unsigned        pick;
		int unsigned        sh;
		pick = $urandom_range(0, 99);
		it.restart      = 1'b0;
		it.command_high = $urandom;
		it.command_low  = $urandom;
		if (pick < 5) begin
			it.restart = 1'b1;
		end else if (pick < 15) begin
			it.command_high[31:24] = rmst_pkg::OP_ENV_COLOR;
		end else if (pick < 25) begin
			it.command_high[31:24] = rmst_pkg::OP_PRIM_COLOR;
		end else if (pick < 55) begin
			it.command_high[31:24] = (pick < 42) ? rmst_pkg::OP_MODE_LOW
				: rmst_pkg::OP_MODE_HIGH;
			// keep shift and count in range most of the time
			if ($urandom_range(0, 4) != 0) begin
				sh = $urandom_range(0, 31);
				it.command_high[15:8] = 8'(sh);
				it.command_high[7:0]  = 8'($urandom_range(1, 32 - sh));
			end
		end else if (pick < 68) begin
			it.command_high[31:24] = rmst_pkg::OP_MODE_FULL;
			// drop flag groups independently to spread the transparency classes
			if ($urandom_range(0, 1))
				it.command_low = it.command_low & ~rmst_pkg::ZMODE_FIELD;
			if ($urandom_range(0, 1))
				it.command_low = it.command_low & ~rmst_pkg::ALPHA_TEST_MSK;
			if ($urandom_range(0, 1))
				it.command_low = it.command_low & ~rmst_pkg::FORCE_BLEND;
		end else if (pick < 92) begin
			it.command_high[31:24] = (pick < 80) ? rmst_pkg::OP_GEOM_SET
				: rmst_pkg::OP_GEOM_CLEAR;
			if ($urandom_range(0, 3) != 0)
				it.command_low = it.command_low & GEOM_WATCHED;
		end
		return it;
	endfunction

	task automatic cfg_write(input logic v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Offer one command beat and hold it until accepted
	task automatic send_cmd(input rmst_pkg::in_item_t it);
		in_item <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic idle_gap(input int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Stop offering and wait until every predicted result has come back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	initial begin : stimulus
		int burst_left;
		logic gapless;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		hold_asked = 0;
		burst_left = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		cfg_write(1'b0);

		// Directed: reset state, alphas, range checks on masked writes, every class, geometry
		send_cmd(make_cmd(OP_UNKNOWN_LO, 24'h000000, 32'h0000_0000));
		send_cmd(make_cmd(rmst_pkg::OP_ENV_COLOR, 24'hFFFFFF, 32'hFFFF_FF00));
		send_cmd(make_cmd(rmst_pkg::OP_PRIM_COLOR, 24'h000000, 32'h0000_00A5));
		send_cmd(span_cmd(rmst_pkg::OP_MODE_LOW, 8'd0, 8'd0, 32'hFFFF_FFFF));
		send_cmd(span_cmd(rmst_pkg::OP_MODE_LOW, 8'd32, 8'd1, 32'hFFFF_FFFF));
		send_cmd(span_cmd(rmst_pkg::OP_MODE_LOW, 8'd31, 8'd2, 32'hFFFF_FFFF));
		send_cmd(span_cmd(rmst_pkg::OP_MODE_LOW, 8'd31, 8'd1, 32'h8000_0000));
		send_cmd(span_cmd(rmst_pkg::OP_MODE_LOW, 8'd0, 8'd32, 32'hFFFF_FFFF));
		send_cmd(span_cmd(rmst_pkg::OP_MODE_LOW, 8'd10, 8'd2, 32'h0000_0000));
		send_cmd(span_cmd(rmst_pkg::OP_MODE_LOW, 8'd255, 8'd255, 32'h0000_0000));
		send_cmd(span_cmd(rmst_pkg::OP_MODE_HIGH, 8'd0, 8'd24, 32'hFFFF_FFFF));
		send_cmd(make_cmd(rmst_pkg::OP_MODE_FULL, 24'hFFFFFF, 32'h0000_0030));
		send_cmd(make_cmd(rmst_pkg::OP_MODE_FULL, 24'h000000, 32'h0000_0001));
		send_cmd(make_cmd(rmst_pkg::OP_MODE_FULL, 24'h123456, 32'h0000_4002));
		send_cmd(make_cmd(rmst_pkg::OP_MODE_FULL, 24'h000000, 32'h0000_4000));
		send_cmd(make_cmd(rmst_pkg::OP_MODE_FULL, 24'h000000, 32'h0000_0C30));
		send_cmd(make_cmd(rmst_pkg::OP_GEOM_SET, 24'h000000, GEOM_WATCHED));
		send_cmd(make_cmd(rmst_pkg::OP_GEOM_CLEAR, 24'h000000, ZBUF_BIT));
		send_cmd(make_cmd(rmst_pkg::OP_GEOM_CLEAR, 24'hFFFFFF, 32'hFFFF_FFFF));
		send_cmd(make_cmd(rmst_pkg::OP_GEOM_SET, 24'hFFFFFF, 32'hFFFF_FFFF));
		send_cmd(rmst_pkg::in_item_t'{1'b1, {rmst_pkg::OP_GEOM_SET, 24'hFFFFFF},
			32'hFFFF_FFFF});
		send_cmd(make_cmd(OP_UNKNOWN_HI, 24'hFFFFFF, 32'hFFFF_FFFF));
		drain();

		// Translucent defaults on restart
		cfg_write(1'b1);
		send_cmd(rmst_pkg::in_item_t'{1'b1, 32'h0000_0000, 32'h0000_0000});
		send_cmd(span_cmd(rmst_pkg::OP_MODE_LOW, 8'd3, 8'd29, 32'h0000_0000));
		send_cmd(make_cmd(rmst_pkg::OP_PRIM_COLOR, 24'h000000, 32'h0000_0000));
		drain();

		// Random phases, register changed between them
		for (int ph = 0; ph < PHASES; ph++) begin
			cfg_write(ph[0]);
			gapless = (ph == 1);
			if ($urandom_range(0, 9) < 7)
				send_cmd(rmst_pkg::in_item_t'{1'b1, $urandom, $urandom});
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// long receiver hold-off while commands keep coming
				if (ph == 2 && n == 20)
					hold_asked++;
				// pause until everything has come back
				if (ph == 3 && n == 40)
					drain();
				if (burst_left == 0) begin
					if (!gapless && $urandom_range(0, 3) != 0)
						idle_gap($urandom_range(1, 6));
					burst_left = $urandom_range(1, 24);
				end
				burst_left--;
				send_cmd(random_cmd());
			end
			drain();
		end

		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== render_mode_state_tracker_top.f =====
rtl/rmst_pkg.sv
rtl/rmst_update.sv
rtl/render_mode_state_tracker_top.sv
tb/rmst_flags_checker.sv
tb/render_mode_state_tracker_top_test.sv
